>>> rtl/b32e_pkg.sv
package b32e_pkg;

	localparam int SYM_W   = 5;
	localparam int ASCII_W = 7;
	localparam int MAX_SYM = 4;

	// One accepted item after classification: the symbol indices it yields,
	// how many of them are valid, and whether it closes the message.
	typedef struct packed {
		logic [MAX_SYM-1:0][SYM_W-1:0] idx;
		logic [2:0]                    n_sym;
		logic                          msg_end;
	} job_t;

	typedef logic [ASCII_W-1:0] ascii_t;

	localparam ascii_t ALPHABET [32] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
		7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51,
		7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
	};

	function automatic ascii_t sym_ascii(input logic [SYM_W-1:0] code);
		return ALPHABET[code];
	endfunction

endpackage

>>> rtl/b32e_if.sv
interface b32e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;
	logic       empty_message;

	modport source (output valid, output data_byte, output is_last, output empty_message,
		input ready);
	modport sink (input valid, input data_byte, input is_last, input empty_message,
		output ready);
endinterface

interface b32e_sym_if;
	logic                         valid;
	logic                         ready;
	logic [b32e_pkg::ASCII_W-1:0] symbol;
	logic                         last_symbol;

	modport source (output valid, output symbol, output last_symbol, input ready);
	modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

>>> rtl/b32e_front.sv
module b32e_front (
	input  logic            clk,
	input  logic            arst_n,
	b32e_byte_if.sink       msg,
	input  logic            q_full,
	output logic            q_push,
	output b32e_pkg::job_t  q_job
);

	logic [3:0]  pend_q;
	logic [2:0]  cnt_q;
	logic        is_end;
	logic        long_item;
	logic [4:0]  total;
	logic [2:0]  n_sym;
	logic [4:0]  rem;
	logic [2:0]  gap;
	logic [3:0]  pend_al;
	logic [15:0] data_al;
	logic [23:0] window;
	logic [3:0]  rem_mask;

	assign msg.ready = !q_full;
	assign q_push    = msg.valid && !q_full;

	always_comb begin
		is_end    = msg.empty_message || msg.is_last;
		// A last byte carries its own eight bits plus the appended zero byte.
		long_item = !msg.empty_message && msg.is_last;
		total     = 5'({2'b00, cnt_q} + (long_item ? 5'd16 : 5'd8));
		if (total >= 5'd20) begin
			n_sym = 3'd4;
		end else if (total >= 5'd15) begin
			n_sym = 3'd3;
		end else if (total >= 5'd10) begin
			n_sym = 3'd2;
		end else begin
			n_sym = 3'd1;
		end
		rem      = 5'(total - 5'({n_sym, 2'b00} + {2'b00, n_sym}));
		gap      = 3'(3'd4 - cnt_q);
		// Left-align pending bits and new data so symbol k sits at a fixed slice.
		pend_al  = 4'(pend_q << gap);
		data_al  = msg.empty_message ? 16'h0000 : {msg.data_byte, 8'h00};
		window   = {pend_al, 20'h00000} | 24'({4'h0, data_al, 4'h0} << gap);
		rem_mask = 4'((5'd1 << rem) - 5'd1);
		for (int k = 0; k < b32e_pkg::MAX_SYM; k++) begin
			q_job.idx[k] = window[23 - 5*k -: b32e_pkg::SYM_W];
		end
		q_job.n_sym   = n_sym;
		q_job.msg_end = is_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'h0;
			cnt_q  <= 3'd0;
		end else if (q_push) begin
			if (is_end) begin
				pend_q <= 4'h0;
				cnt_q  <= 3'd0;
			end else begin
				pend_q <= msg.data_byte[3:0] & rem_mask;
				cnt_q  <= rem[2:0];
			end
		end
	end

endmodule

>>> rtl/b32e_queue.sv
module b32e_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b32e_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output b32e_pkg::job_t  head
);

	b32e_pkg::job_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     fill_q;

	assign full  = fill_q == 2'd2;
	assign empty = fill_q == 2'd0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				fill_q <= 2'(fill_q + 2'd1);
			end else if (pop && !push) begin
				fill_q <= 2'(fill_q - 2'd1);
			end
		end
	end

endmodule

>>> rtl/b32e_back.sv
module b32e_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  b32e_pkg::job_t  q_head,
	output logic            q_pop,
	b32e_sym_if.source      sym
);

	logic [1:0] k_q;
	logic       at_tail;
	logic       fire;

	assign at_tail         = {1'b0, k_q} == 3'(q_head.n_sym - 3'd1);
	assign fire            = sym.valid && sym.ready;
	assign sym.valid       = !q_empty;
	assign sym.symbol      = b32e_pkg::sym_ascii(q_head.idx[k_q]);
	assign sym.last_symbol = q_head.msg_end && at_tail;
	assign q_pop           = fire && at_tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 2'd0;
		end else if (fire) begin
			k_q <= at_tail ? 2'd0 : 2'(k_q + 2'd1);
		end
	end

endmodule

>>> rtl/base32_symbol_encoder.sv
// Channel | Role | Payload
// msg     | sink   | data_byte[7:0], is_last, empty_message
// sym     | source | symbol[6:0], last_symbol
//
// The front stage takes one request per cycle while the two-entry job queue has room.
// The back stage sends one symbol per cycle while sym is ready.
// A byte yields one or two symbols and a final byte three or four.
// Reset clears the bit buffer, the queue pointers and the symbol counter.
// A stall on sym holds the current symbol; msg keeps flowing until the queue fills.
module base32_symbol_encoder (
	input  logic       clk,
	input  logic       arst_n,
	b32e_byte_if.sink  msg,
	b32e_sym_if.source sym
);

	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	b32e_pkg::job_t q_job;
	b32e_pkg::job_t q_head;

	b32e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (q_job)
	);

	b32e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	b32e_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.sym     (sym)
	);

endmodule

>>> verif/base32_symbol_encoder_test.sv
module base32_symbol_encoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		b32e_pkg::ascii_t symbol;
		logic             last_symbol;
	} sym_t;

	// A zero n_want leaves the row to the predictor; otherwise want holds the
	// expected symbols as text, right aligned, the final one marked last.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        is_last;
		logic        empty_message;
		logic [2:0]  n_want;
		logic [31:0] want;
	} stim_row_t;

	localparam int N_DIRECTED   = 24;
	localparam int N_RANDOM     = 206;
	localparam int DRAIN_CYCLES = 20;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{8'h00, 1'b0, 1'b1, 3'd1, "0"},
		'{8'h00, 1'b1, 1'b0, 3'd3, "000"},
		'{8'hFF, 1'b1, 1'b0, 3'd3, "ZW0"},
		'{8'hFF, 1'b1, 1'b1, 3'd1, "0"},
		'{8'hFF, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'h80, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'h01, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'hFF, 1'b1, 1'b0, 3'd0, 32'd0},
		'{8'hAA, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'h55, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'h0F, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'hA5, 1'b1, 1'b1, 3'd0, 32'd0},
		'{8'hF0, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'h00, 1'b0, 1'b1, 3'd0, 32'd0},
		'{8'h3C, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'hC3, 1'b1, 1'b0, 3'd0, 32'd0},
		'{8'h7F, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'h80, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'h5A, 1'b0, 1'b1, 3'd0, 32'd0},
		'{8'h01, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'h02, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'h04, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'h08, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'hFE, 1'b1, 1'b0, 3'd0, 32'd0}
	};

	logic clk;
	logic arst_n;

	b32e_byte_if msg_if();
	b32e_sym_if  sym_if();

	base32_symbol_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.sym    (sym_if)
	);

	string      crock_digits = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
	logic [3:0] pend_bits;
	logic [2:0] pend_cnt;
	sym_t       pred_q[$];
	sym_t       due_syms[$];
	int         mismatches = 0;
	logic       steady;
	logic [2:0] cur_n_want;
	logic [31:0] cur_want;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("[base32_symbol_encoder] ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Pending bits only ever hold pend_cnt valid bits, the rest stay zero.
	function automatic void shift_in_byte(input logic [7:0] b);
		logic [11:0] acc;
		int          cnt;
		int          sh;
		logic [4:0]  idx;
		sym_t        s;
		acc = {pend_bits, b};
		cnt = pend_cnt + 8;
		while (cnt >= b32e_pkg::SYM_W) begin
			sh = cnt - b32e_pkg::SYM_W;
			idx = acc[sh +: b32e_pkg::SYM_W];
			s.symbol = b32e_pkg::ascii_t'(crock_digits[idx]);
			s.last_symbol = 1'b0;
			pred_q.push_back(s);
			cnt = sh;
			acc = acc & ((12'd1 << cnt) - 12'd1);
		end
		pend_bits = acc[3:0];
		pend_cnt = 3'(cnt);
	endfunction

	function automatic void encode_request(input logic [7:0] b, input logic last,
		input logic empty);
		sym_t s;
		pred_q.delete();
		if (!empty)
			shift_in_byte(b);
		if (empty || last) begin
			shift_in_byte(8'h00);
			s = pred_q.pop_back();
			s.last_symbol = 1'b1;
			pred_q.push_back(s);
			pend_bits = 4'd0;
			pend_cnt = 3'd0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track_symbols
		sym_t got;
		sym_t want;
		if (!arst_n) begin
			pend_bits = 4'd0;
			pend_cnt = 3'd0;
		end else begin
			if (msg_if.valid && msg_if.ready) begin
				encode_request(msg_if.data_byte, msg_if.is_last, msg_if.empty_message);
				if (cur_n_want != 3'd0) begin
					for (int i = 0; i < cur_n_want; i++) begin
						want.symbol = cur_want[8 * (cur_n_want - 1 - i) +: b32e_pkg::ASCII_W];
						want.last_symbol = (i == cur_n_want - 1);
						due_syms.push_back(want);
					end
				end else begin
					foreach (pred_q[i])
						due_syms.push_back(pred_q[i]);
				end
			end
			if (sym_if.valid && sym_if.ready) begin
				got.symbol = sym_if.symbol;
				got.last_symbol = sym_if.last_symbol;
				if (due_syms.size() == 0) begin
					$display("%0t: symbol with none expected: expected nothing, actual %c last %b",
						$time, got.symbol, got.last_symbol);
					mismatches++;
				end else begin
					want = due_syms.pop_front();
					if (got.symbol !== want.symbol) begin
						$display("%0t: symbol: expected %c (%h), actual %c (%h)",
							$time, want.symbol, want.symbol, got.symbol, got.symbol);
						mismatches++;
					end
					if (got.last_symbol !== want.last_symbol) begin
						$display("%0t: last_symbol: expected %b, actual %b",
							$time, want.last_symbol, got.last_symbol);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin : pace_symbols
		int stall;
		sym_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!steady && $urandom_range(0, 3) == 0) begin
				stall = pick_gap() + 1;
				sym_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			sym_if.ready <= 1'b1;
		end
	end

	task automatic send_request(input logic [7:0] b, input logic last, input logic empty,
		input logic [2:0] n_want, input logic [31:0] want);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			msg_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_if.valid <= 1'b1;
		msg_if.data_byte <= b;
		msg_if.is_last <= last;
		msg_if.empty_message <= empty;
		cur_n_want <= n_want;
		cur_want <= want;
		do @(posedge clk); while (!msg_if.ready);
	endtask

	// Sampled on the falling edge so that the tracker has settled for the cycle.
	task automatic wait_for_drain();
		msg_if.valid <= 1'b0;
		do @(negedge clk); while (due_syms.size() != 0);
		@(posedge clk);
	endtask

	initial begin : drive_requests
		int   sent;
		int   kind;
		int   msg_len;
		logic paused;
		arst_n = 1'b0;
		msg_if.valid <= 1'b0;
		msg_if.data_byte <= 8'h00;
		msg_if.is_last <= 1'b0;
		msg_if.empty_message <= 1'b0;
		steady <= 1'b0;
		cur_n_want <= 3'd0;
		cur_want <= 32'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].data_byte, directed_rows[i].is_last,
				directed_rows[i].empty_message, directed_rows[i].n_want,
				directed_rows[i].want);
		wait_for_drain();

		sent = 0;
		paused = 1'b0;
		while (sent < N_RANDOM) begin
			steady <= (sent >= 120 && sent < 150);
			if (!paused && sent >= 90) begin
				paused = 1'b1;
				wait_for_drain();
			end
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				// A zero-length message; byte and last flag are don't-cares.
				send_request(8'($urandom), 1'($urandom), 1'b1, 3'd0, 32'd0);
				sent++;
			end else if (kind < 18) begin
				// Message cut short by an empty marker instead of a last byte.
				msg_len = $urandom_range(1, 5);
				repeat (msg_len) begin
					send_request(8'($urandom), 1'b0, 1'b0, 3'd0, 32'd0);
					sent++;
				end
				send_request(8'($urandom), 1'($urandom), 1'b1, 3'd0, 32'd0);
				sent++;
			end else begin
				msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
					: $urandom_range(1, 6);
				for (int i = 0; i < msg_len; i++) begin
					send_request(8'($urandom), (i == msg_len - 1), 1'b0, 3'd0, 32'd0);
					sent++;
				end
			end
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[base32_symbol_encoder] OK");
		else
			$display("[base32_symbol_encoder] ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/b32e_pkg.sv
rtl/b32e_if.sv
rtl/b32e_front.sv
rtl/b32e_queue.sv
rtl/b32e_back.sv
rtl/base32_symbol_encoder.sv
verif/base32_symbol_encoder_test.sv
